@@ design/rld_pkg.sv @@
package rld_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 512;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffW    = 9;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned KindW   = 2;
  localparam int unsigned EventW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPreamble   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCrcInit    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCrcXor     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStatusLen  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpectrumLen = 3'd4;
  localparam logic [CfgIdxW-1:0] RegParamLen   = 3'd5;

  // register reset values
  localparam logic [WordW-1:0] PreambleRst  = 32'h2f762a24;
  localparam logic [WordW-1:0] CrcInitRst   = 32'h314d9b87;
  localparam logic [WordW-1:0] CrcXorRst    = 32'h768af41a;
  localparam logic [OffW-1:0]  StatusLenRst = 9'd165;
  localparam logic [OffW-1:0]  SpecLenRst   = 9'd262;
  localparam logic [OffW-1:0]  ParamLenRst  = 9'd6;

  localparam logic [WordW-1:0] CrcPoly = 32'h04C11DB7;

  // packet id bytes
  localparam logic [ByteW-1:0] IdStatus   = 8'h53;
  localparam logic [ByteW-1:0] IdSpectrum = 8'h52;
  localparam logic [ByteW-1:0] IdParam    = 8'h58;

  localparam logic [OffW-1:0] HdrBytes      = 9'd5;
  localparam logic [OffW-1:0] TrailerBytes  = 9'd4;
  localparam logic [OffW-1:0] StatusMinLen  = 9'd9;
  localparam logic [OffW-1:0] MaxLen        = OffW'(MAX_PACKET_BYTES - 1);
  localparam logic [OffW-1:0] PreambleLast  = 9'd4;

  typedef enum logic [KindW-1:0] {
    KIND_NONE     = 2'd0,
    KIND_STATUS   = 2'd1,
    KIND_SPECTRUM = 2'd2,
    KIND_PARAM    = 2'd3
  } kind_t;

  typedef enum logic [EventW-1:0] {
    EV_PROGRESS    = 3'd0,
    EV_GOOD        = 3'd1,
    EV_PREAMBLE    = 3'd2,
    EV_UNKNOWN_ID  = 3'd3,
    EV_CRC_FAIL    = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'b01,
    PH_BODY = 2'b10
  } phase_t;

  // configuration as seen by the deframer, lengths already clamped
  typedef struct packed {
    logic [WordW-1:0] preamble;
    logic [WordW-1:0] crc_init;
    logic [WordW-1:0] crc_xor;
    logic [OffW-1:0]  stat_total;
    logic [OffW-1:0]  spec_total;
    logic [OffW-1:0]  prm_total;
  } cfg_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = b[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] rev32(input logic [WordW-1:0] x);
    logic [WordW-1:0] r;
    for (int i = 0; i < WordW; i++) begin
      r[i] = x[WordW-1-i];
    end
    return r;
  endfunction

  function automatic logic [OffW-1:0] fit_len(input logic [OffW-1:0] len,
                                             input logic [OffW-1:0] min_len);
    logic [OffW-1:0] r;
    r = (len < min_len) ? min_len : len;
    if (r > MaxLen) begin
      r = MaxLen;
    end
    return r;
  endfunction

endpackage

@@ design/rld_if.sv @@
interface rld_in_if;
  logic                       valid;
  logic                       ready;
  logic [rld_pkg::ByteW-1:0]  rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rld_out_if;
  logic                        valid;
  logic                        ready;
  logic [rld_pkg::ByteW-1:0]   payload_byte;
  logic [rld_pkg::OffW-1:0]    byte_offset;
  logic                        byte_in_packet;
  logic [rld_pkg::KindW-1:0]   packet_kind;
  logic [rld_pkg::EventW-1:0]  frame_event;
  modport source (output valid, output payload_byte, output byte_offset,
                  output byte_in_packet, output packet_kind, output frame_event,
                  input ready);
  modport sink (input valid, input payload_byte, input byte_offset,
                input byte_in_packet, input packet_kind, input frame_event,
                output ready);
endinterface

interface rld_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rld_pkg::CfgIdxW-1:0] index;
  logic [rld_pkg::WordW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/radio_link_packet_deframer.sv @@
// channel | dir | handshake   | payload
// in_if   | in  | valid/ready | rx_byte
// out_if  | out | valid/ready | payload_byte, byte_offset, byte_in_packet,
//         |     |             | packet_kind, frame_event
// cfg_if  | in  | valid/ready | index, data (ready always high)
//
// one byte per cycle sustained while out_if does not stall; a byte passes
// the input register and then the result register before out_if shows it
// the per-byte cost is one unrolled 8-bit crc-32 update plus compare logic
// rst_n is synchronous, active low; it restores register defaults and hunting
// a stall on out_if holds the result register, then the input register,
// and only then drops in_if.ready
module radio_link_packet_deframer (
  input  logic      clk,
  input  logic      rst_n,
  rld_in_if.sink    in_if,
  rld_out_if.source out_if,
  rld_cfg_if.sink   cfg_if
);

  rld_pkg::cfg_t              cfg;

  // input register stage
  logic                       in_valid_r, in_valid_nxt;
  logic [rld_pkg::ByteW-1:0]  in_byte_r;
  logic                       item_take;
  logic                       in_xfer;

  assign in_if.ready  = !in_valid_r || item_take;
  assign in_xfer      = in_if.valid && in_if.ready;
  // hold the byte while the deframer stage is stalled
  assign in_valid_nxt = in_xfer ? 1'b1 : (item_take ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_if.rx_byte;
    end
  end

  // configuration registers, lengths clamped
  rld_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // header hunt, body tracking, crc check and result register
  rld_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_valid_r),
    .item_byte  (in_byte_r),
    .item_take  (item_take),
    .out_if     (out_if)
  );

endmodule

@@ design/rld_cfg.sv @@
module rld_cfg (
  input  logic             clk,
  input  logic             rst_n,
  rld_cfg_if.sink          cfg_if,
  output rld_pkg::cfg_t    cfg
);

  logic [rld_pkg::WordW-1:0] preamble_r, preamble_nxt;
  logic [rld_pkg::WordW-1:0] crc_init_r, crc_init_nxt;
  logic [rld_pkg::WordW-1:0] crc_xor_r, crc_xor_nxt;
  logic [rld_pkg::OffW-1:0]  stat_len_r, stat_len_nxt;
  logic [rld_pkg::OffW-1:0]  spec_len_r, spec_len_nxt;
  logic [rld_pkg::OffW-1:0]  prm_len_r, prm_len_nxt;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    preamble_nxt   = preamble_r;
    crc_init_nxt   = crc_init_r;
    crc_xor_nxt    = crc_xor_r;
    stat_len_nxt   = stat_len_r;
    spec_len_nxt   = spec_len_r;
    prm_len_nxt    = prm_len_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        rld_pkg::RegPreamble:    preamble_nxt   = cfg_if.data;
        rld_pkg::RegCrcInit:     crc_init_nxt   = cfg_if.data;
        rld_pkg::RegCrcXor:      crc_xor_nxt    = cfg_if.data;
        rld_pkg::RegStatusLen:   stat_len_nxt   = cfg_if.data[rld_pkg::OffW-1:0];
        rld_pkg::RegSpectrumLen: spec_len_nxt   = cfg_if.data[rld_pkg::OffW-1:0];
        rld_pkg::RegParamLen:    prm_len_nxt    = cfg_if.data[rld_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r   <= rld_pkg::PreambleRst;
      crc_init_r   <= rld_pkg::CrcInitRst;
      crc_xor_r    <= rld_pkg::CrcXorRst;
      stat_len_r   <= rld_pkg::StatusLenRst;
      spec_len_r   <= rld_pkg::SpecLenRst;
      prm_len_r    <= rld_pkg::ParamLenRst;
    end else begin
      preamble_r   <= preamble_nxt;
      crc_init_r   <= crc_init_nxt;
      crc_xor_r    <= crc_xor_nxt;
      stat_len_r   <= stat_len_nxt;
      spec_len_r   <= spec_len_nxt;
      prm_len_r    <= prm_len_nxt;
    end
  end

  // lengths clamped to the legal packet range
  always_comb begin
    cfg.preamble   = preamble_r;
    cfg.crc_init   = crc_init_r;
    cfg.crc_xor    = crc_xor_r;
    cfg.stat_total = rld_pkg::fit_len(stat_len_r, rld_pkg::StatusMinLen);
    cfg.spec_total = rld_pkg::fit_len(spec_len_r, rld_pkg::HdrBytes);
    cfg.prm_total  = rld_pkg::fit_len(prm_len_r, rld_pkg::HdrBytes);
  end

endmodule

@@ design/rld_crc8.sv @@
module rld_crc8 (
  input  logic [rld_pkg::WordW-1:0] crc_in,
  input  logic [rld_pkg::ByteW-1:0] data,
  output logic [rld_pkg::WordW-1:0] crc_out
);

  logic [rld_pkg::WordW-1:0] c;

  // byte reflected into the top, then eight msb-first shifts
  always_comb begin
    c = crc_in ^ {rld_pkg::rev8(data), {(rld_pkg::WordW-rld_pkg::ByteW){1'b0}}};
    for (int i = 0; i < rld_pkg::ByteW; i++) begin
      c = c[rld_pkg::WordW-1] ? ((c << 1) ^ rld_pkg::CrcPoly) : (c << 1);
    end
    crc_out = c;
  end

endmodule

@@ design/rld_core.sv @@
module rld_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rld_pkg::cfg_t              cfg,
  input  logic                       item_valid,
  input  logic [rld_pkg::ByteW-1:0]  item_byte,
  output logic                       item_take,
  rld_out_if.source                  out_if
);

  localparam int unsigned SumW = rld_pkg::OffW + 1;

  rld_pkg::phase_t            phase_r, phase_nxt;
  logic [rld_pkg::OffW-1:0]   seen_r, seen_nxt;
  logic [rld_pkg::WordW-1:0]  hdr_r, hdr_nxt;
  rld_pkg::kind_t             kind_r, kind_nxt;
  logic [rld_pkg::OffW-1:0]   total_r, total_nxt;
  logic [rld_pkg::WordW-1:0]  crc_r, crc_nxt;
  logic [rld_pkg::WordW-1:0]  trl_r, trl_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [rld_pkg::ByteW-1:0]  o_byte_r;
  logic [rld_pkg::OffW-1:0]   o_off_r;
  logic                       o_inpkt_r;
  rld_pkg::kind_t             o_kind_r;
  rld_pkg::event_t            o_ev_r;

  logic                       fire;
  logic [rld_pkg::WordW-1:0]  crc_base;
  logic [rld_pkg::WordW-1:0]  crc_upd;
  logic [rld_pkg::WordW-1:0]  fin_crc;
  logic [SumW-1:0]            off_p_trl;
  logic [SumW-1:0]            off_p_one;
  logic                       inpkt;
  rld_pkg::kind_t             kind;
  rld_pkg::event_t            ev;
  logic [rld_pkg::OffW-1:0]   id_len;
  logic                       back_to_hunt;

  assign item_take = !out_valid_r || out_if.ready;
  assign fire      = item_valid && item_take;

  // crc restarts on the first header byte
  assign crc_base = (phase_r == rld_pkg::PH_HUNT && seen_r == '0) ? cfg.crc_init : crc_r;

  rld_crc8 u_crc (
    .crc_in  (crc_base),
    .data    (item_byte),
    .crc_out (crc_upd)
  );

  assign off_p_trl = SumW'(seen_r) + SumW'(rld_pkg::TrailerBytes);
  assign off_p_one = SumW'(seen_r) + SumW'(1);
  assign fin_crc   = rld_pkg::rev32(crc_r) ^ cfg.crc_xor;

  always_comb begin
    phase_nxt    = phase_r;
    seen_nxt     = seen_r;
    hdr_nxt      = hdr_r;
    kind_nxt     = kind_r;
    total_nxt    = total_r;
    crc_nxt      = crc_r;
    trl_nxt      = trl_r;
    inpkt        = 1'b0;
    kind         = rld_pkg::KIND_NONE;
    ev           = rld_pkg::EV_PROGRESS;
    id_len       = rld_pkg::HdrBytes;
    back_to_hunt = 1'b0;

    unique case (phase_r)
      rld_pkg::PH_HUNT: begin
        crc_nxt = crc_upd;
        if (seen_r < rld_pkg::PreambleLast) begin
          hdr_nxt  = {hdr_r[rld_pkg::WordW-rld_pkg::ByteW-1:0], item_byte};
          seen_nxt = seen_r + 1'b1;
        end else if (hdr_r != cfg.preamble) begin
          ev           = rld_pkg::EV_PREAMBLE;
          back_to_hunt = 1'b1;
        end else begin
          unique case (item_byte)
            rld_pkg::IdStatus: begin
              kind   = rld_pkg::KIND_STATUS;
              id_len = cfg.stat_total;
            end
            rld_pkg::IdSpectrum: begin
              kind   = rld_pkg::KIND_SPECTRUM;
              id_len = cfg.spec_total;
            end
            rld_pkg::IdParam: begin
              kind   = rld_pkg::KIND_PARAM;
              id_len = cfg.prm_total;
            end
            default: kind = rld_pkg::KIND_NONE;
          endcase
          if (kind == rld_pkg::KIND_NONE) begin
            ev           = rld_pkg::EV_UNKNOWN_ID;
            back_to_hunt = 1'b1;
          end else begin
            inpkt = 1'b1;
            if (id_len <= rld_pkg::HdrBytes) begin
              ev           = rld_pkg::EV_GOOD;
              back_to_hunt = 1'b1;
            end else begin
              kind_nxt  = kind;
              total_nxt = id_len;
              phase_nxt = rld_pkg::PH_BODY;
              seen_nxt  = rld_pkg::HdrBytes;
            end
          end
        end
      end
      rld_pkg::PH_BODY: begin
        inpkt = 1'b1;
        kind  = kind_r;
        if (kind_r == rld_pkg::KIND_STATUS) begin
          if (off_p_trl < SumW'(total_r)) begin
            crc_nxt = crc_upd;
          end else begin
            trl_nxt = {item_byte, trl_r[rld_pkg::WordW-1:rld_pkg::ByteW]};
          end
        end
        if (off_p_one >= SumW'(total_r)) begin
          if (kind_r == rld_pkg::KIND_STATUS) begin
            ev = (fin_crc == trl_nxt) ? rld_pkg::EV_GOOD : rld_pkg::EV_CRC_FAIL;
          end else begin
            ev = rld_pkg::EV_GOOD;
          end
          back_to_hunt = 1'b1;
        end else begin
          seen_nxt = off_p_one[rld_pkg::OffW-1:0];
        end
      end
      default: back_to_hunt = 1'b1;
    endcase

    if (back_to_hunt) begin
      phase_nxt = rld_pkg::PH_HUNT;
      seen_nxt  = '0;
      hdr_nxt   = '0;
      kind_nxt  = rld_pkg::KIND_NONE;
      total_nxt = '0;
      trl_nxt   = '0;
      crc_nxt   = cfg.crc_init;
    end
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rld_pkg::PH_HUNT;
      seen_r      <= '0;
      kind_r      <= rld_pkg::KIND_NONE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        seen_r  <= seen_nxt;
        kind_r  <= kind_nxt;
        total_r <= total_nxt;
      end
    end
  end

  // shift registers and result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      hdr_r     <= hdr_nxt;
      crc_r     <= crc_nxt;
      trl_r     <= trl_nxt;
      o_byte_r  <= item_byte;
      o_off_r   <= seen_r;
      o_inpkt_r <= inpkt;
      o_kind_r  <= kind;
      o_ev_r    <= ev;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.payload_byte   = o_byte_r;
  assign out_if.byte_offset    = o_off_r;
  assign out_if.byte_in_packet = o_inpkt_r;
  assign out_if.packet_kind    = o_kind_r;
  assign out_if.frame_event    = o_ev_r;

endmodule

@@ bench/radio_link_packet_deframer_tb.sv @@
module radio_link_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rld_pkg::*;

  // one echoed byte as it leaves the block
  typedef struct packed {
    logic [ByteW-1:0] payload;
    logic [OffW-1:0]  offset;
    logic             in_pkt;
    kind_t            kind;
    event_t           ev;
  } frame_res_t;

  // directed stimulus: byte, whether the echo is typed in, and that echo
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    frame_res_t       want;
  } stim_row_t;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam int unsigned HoldCycles = 250;
  localparam int unsigned StallLimit = 2000;
  localparam int          PhaseCount = 6;
  localparam int          PhaseItems = 55;

  // rows before the split run on reset settings, the rest on a zero preamble
  localparam int DirRowCount = 21;
  localparam int SplitRow    = 16;
  localparam stim_row_t DirRows [DirRowCount] = '{
    // good header, parameter reply of six bytes
    '{8'h2f, 1'b1, '{8'h2f, 9'd0, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h76, 1'b1, '{8'h76, 9'd1, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h2a, 1'b1, '{8'h2a, 9'd2, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h24, 1'b1, '{8'h24, 9'd3, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h58, 1'b1, '{8'h58, 9'd4, 1'b1, KIND_PARAM, EV_PROGRESS}},
    '{8'h00, 1'b1, '{8'h00, 9'd5, 1'b1, KIND_PARAM, EV_GOOD}},
    // last preamble byte off by one bit
    '{8'h2f, 1'b1, '{8'h2f, 9'd0, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h76, 1'b1, '{8'h76, 9'd1, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h2a, 1'b1, '{8'h2a, 9'd2, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h25, 1'b1, '{8'h25, 9'd3, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h58, 1'b1, '{8'h58, 9'd4, 1'b0, KIND_NONE,  EV_PREAMBLE}},
    // good preamble, id not known
    '{8'h2f, 1'b1, '{8'h2f, 9'd0, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h76, 1'b1, '{8'h76, 9'd1, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h2a, 1'b1, '{8'h2a, 9'd2, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'h24, 1'b1, '{8'h24, 9'd3, 1'b0, KIND_NONE,  EV_PROGRESS}},
    '{8'hff, 1'b1, '{8'hff, 9'd4, 1'b0, KIND_NONE,  EV_UNKNOWN_ID}},
    // all-zero preamble matches, short spectrum length ends on the id byte
    '{8'h00, 1'b1, '{8'h00, 9'd0, 1'b0, KIND_NONE,     EV_PROGRESS}},
    '{8'h00, 1'b1, '{8'h00, 9'd1, 1'b0, KIND_NONE,     EV_PROGRESS}},
    '{8'h00, 1'b1, '{8'h00, 9'd2, 1'b0, KIND_NONE,     EV_PROGRESS}},
    '{8'h00, 1'b1, '{8'h00, 9'd3, 1'b0, KIND_NONE,     EV_PROGRESS}},
    '{8'h52, 1'b1, '{8'h52, 9'd4, 1'b1, KIND_SPECTRUM, EV_GOOD}}
  };

  logic clk;
  logic rst_n;

  rld_in_if  in_ch ();
  rld_out_if out_ch ();
  rld_cfg_if cfg_ch ();

  radio_link_packet_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // shadow copy of the register file
  logic [WordW-1:0] cfg_preamble;
  logic [WordW-1:0] cfg_crc_init;
  logic [WordW-1:0] cfg_crc_xor;
  logic [OffW-1:0]  cfg_stat_len;
  logic [OffW-1:0]  cfg_spec_len;
  logic [OffW-1:0]  cfg_prm_len;

  // shadow copy of the deframer state
  phase_t           dfr_phase;
  logic [OffW-1:0]  dfr_seen;
  logic [WordW-1:0] dfr_hdr;
  kind_t            dfr_kind;
  logic [OffW-1:0]  dfr_total;
  logic [WordW-1:0] dfr_crc;
  logic [WordW-1:0] dfr_trailer;

  frame_res_t       echo_backlog[$];
  logic [ByteW-1:0] burst_q[$];

  int unsigned faults = 0;
  int unsigned quiet_cycles = 0;

  // handshake shaping shared between the driving processes
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  bit          hold_pending = 1'b0;
  int unsigned rush_left = 0;

  // a typed-in echo for the byte now on offer, if any
  logic        typed_now = 1'b0;
  frame_res_t  typed_want = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  function automatic logic [ByteW-1:0] flip_byte(input logic [ByteW-1:0] b);
    return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
  endfunction

  function automatic logic [WordW-1:0] flip_word(input logic [WordW-1:0] x);
    logic [WordW-1:0] r;
    r = '0;
    // lsb of x ends up as msb after all shifts
    for (int i = 0; i < WordW; i++) begin
      r = {r[WordW-2:0], x[i]};
    end
    return r;
  endfunction

  // reflected byte into the top, then eight msb-first steps
  function automatic logic [WordW-1:0] crc_shift_in(input logic [WordW-1:0] c,
                                                    input logic [ByteW-1:0] b);
    logic [WordW-1:0] r;
    r = c ^ {flip_byte(b), 24'h000000};
    for (int i = 0; i < 8; i++) begin
      r = r[WordW-1] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  // raise short lengths to the floor, cap at MaxLen
  function automatic logic [OffW-1:0] bounded_len(input logic [OffW-1:0] len,
                                                  input logic [OffW-1:0] least);
    logic [OffW-1:0] r;
    r = (len < least) ? least : len;
    if (r > MaxLen) begin
      r = MaxLen;
    end
    return r;
  endfunction

  task automatic return_to_hunt();
    dfr_phase   = PH_HUNT;
    dfr_seen    = '0;
    dfr_hdr     = '0;
    dfr_kind    = KIND_NONE;
    dfr_total   = '0;
    dfr_trailer = '0;
    dfr_crc     = cfg_crc_init;
  endtask

  task automatic restore_defaults();
    cfg_preamble = PreambleRst;
    cfg_crc_init = CrcInitRst;
    cfg_crc_xor  = CrcXorRst;
    cfg_stat_len = StatusLenRst;
    cfg_spec_len = SpecLenRst;
    cfg_prm_len  = ParamLenRst;
    return_to_hunt();
  endtask

  // one received byte in, its echo out
  task automatic deframe_byte(input logic [ByteW-1:0] b, output frame_res_t r);
    logic [OffW-1:0] off;
    kind_t           k;
    off = dfr_seen;
    r = '{payload: b, offset: off, in_pkt: 1'b0, kind: KIND_NONE, ev: EV_PROGRESS};
    if (dfr_phase != PH_BODY) begin
      // crc restarts on the first header byte
      if (off == '0) begin
        dfr_crc = cfg_crc_init;
      end
      dfr_crc = crc_shift_in(dfr_crc, b);
      if (off < HdrBytes - 1) begin
        dfr_hdr  = {dfr_hdr[23:0], b};
        dfr_seen = off + 1'b1;
      end else if (dfr_hdr != cfg_preamble) begin
        r.ev = EV_PREAMBLE;
        return_to_hunt();
      end else begin
        // id byte latches kind and length
        k = KIND_NONE;
        case (b)
          IdStatus: begin
            k = KIND_STATUS;
            dfr_total = bounded_len(cfg_stat_len, StatusMinLen);
          end
          IdSpectrum: begin
            k = KIND_SPECTRUM;
            dfr_total = bounded_len(cfg_spec_len, HdrBytes);
          end
          IdParam: begin
            k = KIND_PARAM;
            dfr_total = bounded_len(cfg_prm_len, HdrBytes);
          end
          default: k = KIND_NONE;
        endcase
        if (k == KIND_NONE) begin
          r.ev = EV_UNKNOWN_ID;
          return_to_hunt();
        end else begin
          r.in_pkt = 1'b1;
          r.kind   = k;
          if (dfr_total <= HdrBytes) begin
            // header-only packet
            r.ev = EV_GOOD;
            return_to_hunt();
          end else begin
            dfr_kind    = k;
            dfr_trailer = '0;
            dfr_phase   = PH_BODY;
            dfr_seen    = HdrBytes;
          end
        end
      end
    end else begin
      r.in_pkt = 1'b1;
      r.kind   = dfr_kind;
      if (dfr_kind == KIND_STATUS) begin
        // crc over the body, trailer collected little-endian
        if (int'(off) + int'(TrailerBytes) < int'(dfr_total)) begin
          dfr_crc = crc_shift_in(dfr_crc, b);
        end else begin
          dfr_trailer = {b, dfr_trailer[WordW-1:8]};
        end
      end
      if (int'(off) + 1 >= int'(dfr_total)) begin
        if (dfr_kind == KIND_STATUS) begin
          r.ev = ((flip_word(dfr_crc) ^ cfg_crc_xor) == dfr_trailer) ? EV_GOOD : EV_CRC_FAIL;
        end else begin
          r.ev = EV_GOOD;
        end
        return_to_hunt();
      end else begin
        dfr_seen = off + 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      faults++;
    end
  endtask

  // everything is sampled at the rising edge, before the block updates
  always @(posedge clk) begin : scoreboard
    frame_res_t fresh;
    frame_res_t oldest;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        RegPreamble:    cfg_preamble = cfg_ch.data;
        RegCrcInit:     cfg_crc_init = cfg_ch.data;
        RegCrcXor:      cfg_crc_xor  = cfg_ch.data;
        RegStatusLen:   cfg_stat_len = cfg_ch.data[OffW-1:0];
        RegSpectrumLen: cfg_spec_len = cfg_ch.data[OffW-1:0];
        RegParamLen:    cfg_prm_len  = cfg_ch.data[OffW-1:0];
        default: ;
      endcase
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      // predictor always advances; a typed-in echo replaces its answer
      deframe_byte(in_ch.rx_byte, fresh);
      echo_backlog.push_back(typed_now ? typed_want : fresh);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (echo_backlog.size() == 0) begin
        $error("result transfer with nothing pending: payload_byte %0h offset %0d",
               out_ch.payload_byte, out_ch.byte_offset);
        faults++;
      end else begin
        oldest = echo_backlog.pop_front();
        check_field("payload_byte", 32'(oldest.payload), 32'(out_ch.payload_byte));
        check_field("byte_offset", 32'(oldest.offset), 32'(out_ch.byte_offset));
        check_field("byte_in_packet", 32'(oldest.in_pkt), 32'(out_ch.byte_in_packet));
        check_field("packet_kind", 32'(oldest.kind), 32'(out_ch.packet_kind));
        check_field("frame_event", 32'(oldest.ev), 32'(out_ch.frame_event));
      end
    end
  end

  // cycles without any transfer on any channel
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL radio_link_packet_deframer");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // result side: random stalls, calm stretches, one long hold-off
  // ---------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        calm_out = !calm_out;
      end
      if (hold_pending) begin
        stall = HoldCycles;
        hold_pending = 1'b0;
      end else begin
        stall = calm_out ? 0 : $urandom_range(0, 19);
      end
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                           input frame_res_t want);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) begin
      calm_in = !calm_in;
    end
    if (rush_left != 0) begin
      gap = 0;
      rush_left--;
    end else begin
      gap = calm_in ? 0 : $urandom_range(0, 19);
    end
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    // valid stays high between back-to-back bytes, only the data moves
    in_ch.rx_byte = b;
    typed_now     = typed;
    typed_want    = want;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_burst();
    foreach (burst_q[i]) begin
      send_byte(burst_q[i], 1'b0, '0);
    end
  endtask

  task automatic play_rows(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      send_byte(DirRows[i].b, DirRows[i].typed, DirRows[i].want);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // sender pauses until every echo is back
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (echo_backlog.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic build_header(input logic [WordW-1:0] word, input logic [ByteW-1:0] id);
    for (int i = 3; i >= 0; i--) begin
      burst_q.push_back(word[8*i +: 8]);
    end
    burst_q.push_back(id);
  endtask

  // well-formed packet of the current length; status gets a valid trailer
  // unless spoiled by a single flipped bit after the header
  task automatic build_packet(input kind_t k, input bit spoil);
    logic [ByteW-1:0] id;
    logic [OffW-1:0]  len;
    logic [WordW-1:0] c;
    int               body;
    int               at;
    case (k)
      KIND_STATUS: begin
        id  = IdStatus;
        len = bounded_len(cfg_stat_len, StatusMinLen);
      end
      KIND_SPECTRUM: begin
        id  = IdSpectrum;
        len = bounded_len(cfg_spec_len, HdrBytes);
      end
      default: begin
        id  = IdParam;
        len = bounded_len(cfg_prm_len, HdrBytes);
      end
    endcase
    build_header(cfg_preamble, id);
    body = int'(len) - int'(HdrBytes) - ((k == KIND_STATUS) ? int'(TrailerBytes) : 0);
    repeat (body) burst_q.push_back(8'($urandom_range(0, 255)));
    if (k == KIND_STATUS) begin
      c = cfg_crc_init;
      foreach (burst_q[i]) begin
        c = crc_shift_in(c, burst_q[i]);
      end
      c = flip_word(c) ^ cfg_crc_xor;
      for (int i = 0; i < 4; i++) begin
        burst_q.push_back(c[8*i +: 8]);
      end
      if (spoil) begin
        at = $urandom_range(int'(HdrBytes), int'(len) - 1);
        burst_q[at] = burst_q[at] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
  endtask

  // one random piece: mostly good packets, then broken headers and noise
  task automatic build_piece();
    logic [ByteW-1:0] known_ids [3];
    logic [ByteW-1:0] id;
    int unsigned      roll;
    known_ids = '{IdStatus, IdSpectrum, IdParam};
    burst_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      build_packet(kind_t'($urandom_range(1, 3)), $urandom_range(0, 4) == 0);
    end else if (roll < 80) begin
      // one preamble byte damaged, valid id behind it
      build_header(cfg_preamble ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3))),
                   known_ids[$urandom_range(0, 2)]);
    end else if (roll < 90) begin
      do id = 8'($urandom_range(0, 255));
      while (id == IdStatus || id == IdSpectrum || id == IdParam);
      build_header(cfg_preamble, id);
    end else begin
      repeat (5) burst_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------

  initial begin : stimulus
    logic [WordW-1:0] pre;
    logic [WordW-1:0] ini;
    logic [WordW-1:0] fx;
    logic [OffW-1:0]  sl;
    logic [OffW-1:0]  spl;
    logic [OffW-1:0]  pl;
    int               sent;
    int               budget;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = RegPreamble;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    restore_defaults();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed rows on reset settings
    play_rows(0, SplitRow - 1);
    wait_idle();
    // zero preamble, spectrum length below the header size
    write_reg(RegPreamble, 32'h0000_0000);
    write_reg(RegSpectrumLen, 32'h0000_0000);
    play_rows(SplitRow, DirRowCount - 1);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          // all-zero words, shortest lengths
          pre = '0; ini = '0; fx = '0;
          sl = '0; spl = '0; pl = HdrBytes;
        end
        1: begin
          // all-one words, minimum status length
          pre = '1; ini = '1; fx = '1;
          sl = StatusMinLen; spl = 9'd6; pl = 9'd4;
        end
        PhaseCount - 1: begin
          // one long status packet
          pre = $urandom(); ini = $urandom(); fx = $urandom();
          sl = 9'd120; spl = 9'd120; pl = 9'($urandom_range(0, 10));
        end
        default: begin
          pre = $urandom(); ini = $urandom(); fx = $urandom();
          sl  = 9'($urandom_range(0, 30));
          spl = 9'($urandom_range(0, 30));
          pl  = 9'($urandom_range(0, 30));
        end
      endcase
      wait_idle();
      write_reg(RegPreamble, pre);
      write_reg(RegCrcInit, ini);
      write_reg(RegCrcXor, fx);
      // upper data bits are random, only the low nine count
      write_reg(RegStatusLen, {23'($urandom()), sl});
      write_reg(RegSpectrumLen, {23'($urandom()), spl});
      write_reg(RegParamLen, {23'($urandom()), pl});
      if (p == 3) begin
        write_reg(RegUnused, $urandom());
      end

      sent = 0;
      budget = PhaseItems;
      if (p == 2) begin
        // receiver holds off while bytes keep coming back to back
        hold_pending = 1'b1;
        rush_left = 40;
      end
      if (p == PhaseCount - 1) begin
        // one long status packet with a good trailer
        burst_q.delete();
        build_packet(KIND_STATUS, 1'b0);
        sent = burst_q.size();
        send_burst();
        budget = 40;
      end
      while (sent < budget) begin
        build_piece();
        sent += burst_q.size();
        send_burst();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (faults == 0) begin
      $display("PASS radio_link_packet_deframer");
    end else begin
      $display("FAIL radio_link_packet_deframer");
    end
    $finish;
  end

endmodule
